// File: hdl/rtsp_pkg.sv
package rtsp_pkg;

	localparam int KIND_BITS = 4;
	localparam int OUT_PAYLOAD_BITS = 32;
	localparam int DEPTH_OUT_BITS = 7;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_PEEK  = 2'd2;
	localparam logic [1:0] OP_SHEAR = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BADKIND  = 2'd3;

	localparam logic [KIND_BITS-1:0] KIND_ALT         = 4'd0;
	localparam logic [KIND_BITS-1:0] KIND_CONCAT      = 4'd1;
	localparam logic [KIND_BITS-1:0] KIND_CHARSET     = 4'd2;
	localparam logic [KIND_BITS-1:0] KIND_EMPTYSET    = 4'd3;
	localparam logic [KIND_BITS-1:0] KIND_EMPTYSTRING = 4'd4;
	localparam logic [KIND_BITS-1:0] KIND_PLUS        = 4'd5;
	localparam logic [KIND_BITS-1:0] KIND_STAR        = 4'd6;
	localparam logic [KIND_BITS-1:0] KIND_QUESTION    = 4'd7;

	typedef struct packed {
		logic [1:0]                  opcode;
		logic [KIND_BITS-1:0]        token_kind;
		logic [OUT_PAYLOAD_BITS-1:0] token_payload;
		logic                        keep_removed;
	} req_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic [KIND_BITS-1:0]        out_kind;
		logic [OUT_PAYLOAD_BITS-1:0] out_payload;
		logic                        last;
		logic [DEPTH_OUT_BITS-1:0]   depth_after;
	} rsp_t;

	typedef struct packed {
		logic bad;
		logic done;
	} scan_flags_t;

endpackage

// File: hdl/regex_token_stack_subtree_pop_core.sv
// Token stack for prefix-order regular expressions.
// Request channel (req_valid/req_ready/req): push, pop, peek or shear one
// complete subexpression off the top. Response channel (rsp_valid/rsp_ready/
// rsp): every request gives one response transaction, except a successful kept shear,
// which gives one per removed token, deepest first, with last on the final.
// One request is worked at a time; req_ready is high only when idle.
// A pop or peek does one registered read of the token memory before its
// response; a shear scans down from the top of the stack, one token per
// cycle through the arity step unit. Each further kept token takes a
// memory read, then the response register. A new request is taken only
// once the last response of the previous one has been accepted.
// A stalled receiver holds the response register and the sequencer waits.
// Reset empties the stack; the token memory itself is not cleared, as only
// entries written by a push are ever read.
module regex_token_stack_subtree_pop_core #(
	parameter int STACK_DEPTH  = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rtsp_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rtsp_pkg::rsp_t  rsp
);
	import rtsp_pkg::*;

	localparam int DW  = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int ARW = $clog2(STACK_DEPTH + 2);
	localparam int SW  = (PAYLOAD_BITS < OUT_PAYLOAD_BITS) ? PAYLOAD_BITS
		: OUT_PAYLOAD_BITS;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [SW-1:0]        payload;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_SCAN = 5'b00100,
		S_EMIT = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [DW-1:0] ptr_q, ptr_d;
	logic [DW-1:0] start_q, start_d;
	logic [DW-1:0] emit_q, emit_d;
	logic [ARW-1:0] arity_q, arity_d;
	logic keep_q, keep_d;
	logic pop_q, pop_d;
	logic more_q, more_d;
	rsp_t rsp_q, rsp_d;

	entry_t mem [STACK_DEPTH];
	entry_t rdata_q;
	logic [AW-1:0] rd_addr;
	logic wr_en;

	logic [ARW-1:0] arity_next;
	scan_flags_t step_flags;
	logic [DW-1:0] newptr;
	logic emit_last;

	rtsp_scan_step #(.ARITY_BITS(ARW)) u_step (
		.kind       (rdata_q.kind),
		.arity      (arity_q),
		.arity_next (arity_next),
		.flags      (step_flags)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign rsp = rsp_q;
	assign newptr = ptr_q - DW'(1);
	assign emit_last = (emit_q + DW'(1)) == start_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[depth_q[AW-1:0]] <= '{kind: req.token_kind, payload: req.token_payload[SW-1:0]};
		end
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		ptr_d = ptr_q;
		start_d = start_q;
		emit_d = emit_q;
		arity_d = arity_q;
		keep_d = keep_q;
		pop_d = pop_q;
		more_d = more_q;
		rsp_d = rsp_q;
		rd_addr = AW'(depth_q - DW'(1));
		wr_en = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					rsp_d = '0;
					rsp_d.last = 1'b1;
					more_d = 1'b0;
					unique case (req.opcode)
						OP_PUSH: begin
							state_d = S_RESP;
							if (depth_q >= DW'(STACK_DEPTH)) begin
								rsp_d.status = ST_FULL;
							end else begin
								wr_en = 1'b1;
								depth_d = depth_q + DW'(1);
							end
						end
						OP_POP, OP_PEEK: begin
							pop_d = (req.opcode == OP_POP);
							if (depth_q == '0) begin
								rsp_d.status = ST_EMPTY;
								state_d = S_RESP;
							end else begin
								state_d = S_READ;
							end
						end
						default: begin
							keep_d = req.keep_removed;
							ptr_d = depth_q;
							start_d = depth_q;
							arity_d = ARW'(1);
							if (depth_q == '0) begin
								rsp_d.status = ST_EMPTY;
								state_d = S_RESP;
							end else begin
								state_d = S_SCAN;
							end
						end
					endcase
					rsp_d.depth_after = DEPTH_OUT_BITS'(depth_d);
				end
			end
			S_READ: begin
				if (pop_q) begin
					depth_d = depth_q - DW'(1);
				end
				rsp_d.status = ST_OK;
				rsp_d.out_kind = rdata_q.kind;
				rsp_d.out_payload = OUT_PAYLOAD_BITS'(rdata_q.payload);
				rsp_d.depth_after = DEPTH_OUT_BITS'(depth_d);
				state_d = S_RESP;
			end
			S_SCAN: begin
				rsp_d.depth_after = DEPTH_OUT_BITS'(newptr);
				if (step_flags.bad) begin
					depth_d = newptr;
					rsp_d.status = ST_BADKIND;
					state_d = S_RESP;
				end else if (step_flags.done) begin
					depth_d = newptr;
					if (keep_q) begin
						emit_d = newptr;
						rd_addr = AW'(newptr);
						state_d = S_EMIT;
					end else begin
						rsp_d.status = ST_OK;
						state_d = S_RESP;
					end
				end else if (newptr == '0) begin
					// ran off the bottom before the subexpression closed
					depth_d = '0;
					rsp_d.status = ST_EMPTY;
					state_d = S_RESP;
				end else begin
					ptr_d = newptr;
					arity_d = arity_next;
					rd_addr = AW'(newptr - DW'(1));
				end
			end
			S_EMIT: begin
				rsp_d.status = ST_OK;
				rsp_d.out_kind = rdata_q.kind;
				rsp_d.out_payload = OUT_PAYLOAD_BITS'(rdata_q.payload);
				rsp_d.last = emit_last;
				rsp_d.depth_after = DEPTH_OUT_BITS'(depth_q);
				more_d = !emit_last;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (rsp_ready) begin
					if (more_q) begin
						emit_d = emit_q + DW'(1);
						rd_addr = AW'(emit_q + DW'(1));
						state_d = S_EMIT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			more_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			more_q <= more_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		start_q <= start_d;
		emit_q <= emit_d;
		arity_q <= arity_d;
		keep_q <= keep_d;
		pop_q <= pop_d;
		rsp_q <= rsp_d;
	end

endmodule

// File: hdl/rtsp_scan_step.sv
module rtsp_scan_step #(
	parameter int ARITY_BITS = 7
) (
	input  logic [rtsp_pkg::KIND_BITS-1:0] kind,
	input  logic [ARITY_BITS-1:0]          arity,
	output logic [ARITY_BITS-1:0]          arity_next,
	output rtsp_pkg::scan_flags_t          flags
);
	import rtsp_pkg::*;

	// binary operators open one more operand, leaves close one
	always_comb begin
		flags.bad = 1'b0;
		arity_next = arity;
		case (kind) inside
			KIND_ALT, KIND_CONCAT: arity_next = arity + ARITY_BITS'(1);
			KIND_CHARSET, KIND_EMPTYSET, KIND_EMPTYSTRING:
				arity_next = arity - ARITY_BITS'(1);
			KIND_PLUS, KIND_STAR, KIND_QUESTION: arity_next = arity;
			default: flags.bad = 1'b1;
		endcase
		flags.done = !flags.bad && (arity_next == '0);
	end

endmodule

// File: tb/sv/testbench.sv
module testbench;
	import rtsp_pkg::*;

	localparam int STACK_N = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 300;
	localparam int TAIL_ITEMS = 40;
	localparam int RANDOM_ITEMS = 60;
	localparam logic [KIND_BITS-1:0] KIND_INVALID_LO = 4'd8;
	localparam logic [KIND_BITS-1:0] KIND_INVALID_HI = 4'd15;

	typedef struct {
		req_t r;
		bit   drain;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	stim_t pending_req[$];
	rsp_t expected_rsp[$];

	// shadow copy of the token stack
	logic [KIND_BITS-1:0] kind_mem[STACK_N];
	logic [OUT_PAYLOAD_BITS-1:0] payload_mem[STACK_N];
	int stack_level = 0;
	int peak_level = 0;

	int errors = 0;
	int req_count = 0;
	int rsp_count = 0;
	int full_count = 0;
	int empty_count = 0;
	int badkind_count = 0;
	int emitted_count = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int stall_left = 0;

	regex_token_stack_subtree_pop_core #(
		.STACK_DEPTH(STACK_N),
		.PAYLOAD_BITS(OUT_PAYLOAD_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	function automatic bit in_tail();
		return pending_req.size() < TAIL_ITEMS;
	endfunction

	function automatic rsp_t token_result(logic [1:0] status, logic [KIND_BITS-1:0] kind,
			logic [OUT_PAYLOAD_BITS-1:0] payload, logic last);
		rsp_t t;
		t = '0;
		t.status = status;
		t.out_kind = kind;
		t.out_payload = payload;
		t.last = last;
		return t;
	endfunction

	function automatic void predict_stack_op(req_t r);
		rsp_t batch[$];
		int start;
		int arity;
		int i;
		logic [1:0] err;
		logic [KIND_BITS-1:0] kd;
		case (r.opcode)
			OP_PUSH: begin
				if (stack_level >= STACK_N) begin
					batch.push_back(token_result(ST_FULL, '0, '0, 1'b1));
				end else begin
					kind_mem[stack_level] = r.token_kind;
					payload_mem[stack_level] = r.token_payload;
					stack_level++;
					batch.push_back(token_result(ST_OK, '0, '0, 1'b1));
				end
			end
			OP_POP, OP_PEEK: begin
				if (stack_level == 0) begin
					batch.push_back(token_result(ST_EMPTY, '0, '0, 1'b1));
				end else begin
					batch.push_back(token_result(ST_OK, kind_mem[stack_level - 1],
						payload_mem[stack_level - 1], 1'b1));
					if (r.opcode == OP_POP)
						stack_level--;
				end
			end
			default: begin
				// scanned tokens stay removed even when the scan fails
				start = stack_level;
				arity = 1;
				err = ST_OK;
				while (1) begin
					if (stack_level == 0) begin
						err = ST_EMPTY;
						break;
					end
					stack_level--;
					kd = kind_mem[stack_level];
					if (kd == KIND_ALT || kd == KIND_CONCAT)
						arity++;
					else if (kd <= KIND_EMPTYSTRING)
						arity--;
					else if (kd > KIND_QUESTION) begin
						err = ST_BADKIND;
						break;
					end
					if (arity < 1)
						break;
				end
				if (err != ST_OK)
					batch.push_back(token_result(err, '0, '0, 1'b1));
				else if (!r.keep_removed)
					batch.push_back(token_result(ST_OK, '0, '0, 1'b1));
				else begin
					for (i = stack_level; i < start; i++)
						batch.push_back(token_result(ST_OK, kind_mem[i], payload_mem[i],
							i + 1 == start));
					emitted_count += start - stack_level;
				end
			end
		endcase
		foreach (batch[k]) begin
			batch[k].depth_after = stack_level[DEPTH_OUT_BITS-1:0];
			case (batch[k].status)
				ST_FULL: full_count++;
				ST_EMPTY: empty_count++;
				ST_BADKIND: badkind_count++;
				default: ;
			endcase
			expected_rsp.push_back(batch[k]);
		end
		if (stack_level > peak_level)
			peak_level = stack_level;
	endfunction

	function automatic void check_response(rsp_t got);
		rsp_t want;
		if (expected_rsp.size() == 0) begin
			$error("response transaction with nothing expected: %p", got);
			errors++;
		end else begin
			want = expected_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.out_kind !== want.out_kind) begin
				$error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
				errors++;
			end
			if (got.out_payload !== want.out_payload) begin
				$error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
			if (got.depth_after !== want.depth_after) begin
				$error("depth_after: expected %0d, got %0d", want.depth_after,
					got.depth_after);
				errors++;
			end
		end
		rsp_count++;
	endfunction

	function automatic void add_req(logic [1:0] opcode, logic [KIND_BITS-1:0] kind,
			logic [OUT_PAYLOAD_BITS-1:0] payload, logic keep, bit drain);
		stim_t s;
		s.r.opcode = opcode;
		s.r.token_kind = kind;
		s.r.token_payload = payload;
		s.r.keep_removed = keep;
		s.drain = drain;
		pending_req.push_back(s);
	endfunction

	// random prefix-order expression, pushed so that its root lands on top
	function automatic void add_tree(int max_len, bit drain);
		logic [KIND_BITS-1:0] prefix[$];
		int need;
		int pick;
		int i;
		need = 1;
		while (need > 0) begin
			pick = $urandom_range(0, 2);
			if (prefix.size() + need >= max_len)
				pick = 0;
			case (pick)
				0: begin
					prefix.push_back(KIND_BITS'(KIND_CHARSET + $urandom_range(0, 2)));
					need--;
				end
				1: prefix.push_back(KIND_BITS'(KIND_PLUS + $urandom_range(0, 2)));
				default: begin
					prefix.push_back(KIND_BITS'(KIND_ALT + $urandom_range(0, 1)));
					need++;
				end
			endcase
		end
		for (i = prefix.size() - 1; i >= 0; i--)
			add_req(OP_PUSH, prefix[i], $urandom, 1'($urandom_range(0, 1)),
				drain && i == prefix.size() - 1);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			if (req_valid && req_ready) begin
				predict_stack_op(req);
				req_count++;
			end
			if (!(req_valid && !req_ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_req.size() > 0 &&
						!(pending_req[0].drain && expected_rsp.size() > 0)) begin
					req <= pending_req[0].r;
					req_valid <= 1'b1;
					void'(pending_req.pop_front());
					if (!in_tail() && $urandom_range(0, 4) == 0)
						gap_left = $urandom_range(1, 4);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_response(rsp);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int i;
		int target;
		arst_n = 1'b0;

		// empty stack on every read-type operation
		add_req(OP_POP, KIND_ALT, '0, 1'b0, 1'b0);
		add_req(OP_PEEK, KIND_INVALID_HI, '1, 1'b1, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'b1, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '1, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_CHARSET, 32'hFFFF_FFFF, 1'b1, 1'b0);
		add_req(OP_PEEK, KIND_ALT, '0, 1'b0, 1'b0);
		add_req(OP_POP, KIND_ALT, '0, 1'b0, 1'b0);
		// invalid kind stops the scan, one token missing runs it dry
		add_req(OP_PUSH, KIND_INVALID_HI, '0, 1'b0, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'b1, 1'b0);
		add_req(OP_PUSH, KIND_CONCAT, 32'h1234_5678, 1'b0, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'b1, 1'b0);
		// alt(emptyset, star(emptystring)), kept
		add_req(OP_PUSH, KIND_EMPTYSTRING, 32'h0000_0001, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_STAR, 32'h8000_0000, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_EMPTYSET, 32'h0F0F_0F0F, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_ALT, 32'hF0F0_F0F0, 1'b0, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'b1, 1'b0);
		// plus(question(emptyset)), discarded
		add_req(OP_PUSH, KIND_EMPTYSET, 32'hDEAD_BEEF, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_QUESTION, 32'h0BAD_F00D, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_PLUS, 32'hCAFE_0000, 1'b0, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'b0, 1'b0);
		// a leaf on top removes just itself
		add_req(OP_PUSH, KIND_CHARSET, 32'hAAAA_AAAA, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_EMPTYSTRING, 32'h5555_5555, 1'b0, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'b1, 1'b0);
		add_req(OP_POP, KIND_ALT, '0, 1'b0, 1'b0);

		// full stack: one charset under a chain of stars, then one shear takes all
		add_req(OP_PUSH, KIND_CHARSET, $urandom, 1'b0, 1'b1);
		for (i = 1; i < STACK_N; i++)
			add_req(OP_PUSH, KIND_STAR, $urandom, 1'b0, 1'b0);
		add_req(OP_PUSH, KIND_INVALID_LO, '1, 1'b1, 1'b0);
		add_req(OP_PEEK, KIND_ALT, '0, 1'b0, 1'b0);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'b1, 1'b0);

		target = pending_req.size() + RANDOM_ITEMS;
		add_tree($urandom_range(1, 8), 1'b1);
		add_req(OP_SHEAR, KIND_ALT, '0, 1'($urandom_range(0, 1)), 1'b0);
		while (pending_req.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1: add_req(2'($urandom_range(0, 3)), KIND_BITS'($urandom_range(0, 15)),
					$urandom, 1'($urandom_range(0, 1)), 1'b0);
				2: begin
					// damaged expression: a bad token on top or its root popped off
					add_tree($urandom_range(1, 6), 1'b0);
					if ($urandom_range(0, 1))
						add_req(OP_PUSH,
							KIND_BITS'($urandom_range(KIND_INVALID_LO, KIND_INVALID_HI)),
							$urandom, 1'b0, 1'b0);
					else
						add_req(OP_POP, KIND_ALT, '0, 1'b0, 1'b0);
					add_req(OP_SHEAR, KIND_ALT, $urandom, 1'($urandom_range(0, 1)), 1'b0);
				end
				default: begin
					add_tree($urandom_range(1, 10), $urandom_range(0, 19) == 0);
					if ($urandom_range(0, 3) == 0)
						add_req(OP_PEEK, KIND_BITS'($urandom_range(0, 15)), $urandom,
							1'b0, 1'b0);
					add_req(OP_SHEAR, KIND_BITS'($urandom_range(0, 15)), $urandom,
						$urandom_range(0, 3) != 0, 1'b0);
				end
			endcase
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_req.size() > 0 || req_valid)
			@(posedge clk);
		while (expected_rsp.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("testbench: %0d requests, %0d response transactions, peak depth %0d",
			req_count, rsp_count, peak_level);
		$display("testbench: refusals full %0d, empty %0d, bad kind %0d; %0d tokens kept by shear",
			full_count, empty_count, badkind_count, emitted_count);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
